@@ hw/rtl/assert_macros.svh @@
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock, quiet while in reset
`define AST_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/lflb_pkg.sv @@
package lflb_pkg;
    localparam int MaxTasks   = 64;
    localparam int MaxWorkers = 128;
    localparam int TaskIdxW   = $clog2(MaxTasks);
    localparam int TaskCntW   = $clog2(MaxTasks + 1);
    localparam int WorkerIdxW = 7;
    localparam int WorkerCntW = 8;
    localparam int TotalW     = 38;
    localparam int QueueDepth = 2;

    typedef struct packed {
        logic [15:0] job_id;
        logic [31:0] task_load;
        logic        batch_last;
    } t_req;

    typedef struct packed {
        logic [15:0]       assigned_job;
        logic [6:0]        assigned_worker;
        logic [TotalW-1:0] worker_total;
        logic              overflow;
        logic              result_last;
    } t_rsp;

    // one queued task in sorted order, from the sorter to the assigner
    typedef struct packed {
        logic [15:0] job_id;
        logic [31:0] task_load;
        logic        overflow;
        logic        last;
    } t_task;

    typedef enum logic [2:0] {
        S_LOAD, S_SORT_RD, S_SORT_CMP, S_SORT_WR, S_EMIT_RD, S_EMIT
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE, B_CLEAR, B_SCAN, B_SCAN_WAIT, B_UPDATE, B_OUT
    } t_back_state;
endpackage

@@ hw/rtl/lflb_if.sv @@
interface lflb_req_if import lflb_pkg::*; ();
    logic valid;
    logic ready;
    t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface lflb_rsp_if import lflb_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ hw/rtl/largest_first_load_balancer.sv @@
// largest-first load balancer
// i_req: job requests {job_id, task_load, batch_last}; ready while collecting
// a batch, one request per cycle, up to 64 stored (extra ones set overflow)
// i_num_workers / i_num_workers_we: worker count register, written idle
// o_rsp: one result per stored task, largest load first, with chosen worker,
// its new total, overflow and result_last on the final result
// after batch_last the front end insertion sorts the batch (up to n*n/2
// compares), then streams tasks into a 2-deep queue
// the back end clears 128 worker rows at each batch start and scans the
// active worker rows per task, reading each row in B_SCAN and comparing it
// in B_SCAN_WAIT, then writes the new total in B_UPDATE and sends in B_OUT
// new requests are refused until the whole batch has been sorted and queued
// a stalled receiver holds the result register; the back end and then the
// queue and sorter stall behind it, nothing is dropped
// synchronous active-low reset empties the batch and sets worker count to 1
`include "assert_macros.svh"
module largest_first_load_balancer import lflb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic [WorkerCntW-1:0] i_num_workers,
    input  logic i_num_workers_we,
    lflb_req_if.sink   i_req,
    lflb_rsp_if.source o_rsp
);
    logic [WorkerCntW-1:0] r_num_workers;
    logic  task_valid, q_full, q_empty, q_pop, busy;
    t_task task_in, task_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_num_workers <= WorkerCntW'(1);
        else if (i_num_workers_we) r_num_workers <= i_num_workers;
    end

    lflb_front u_front (
        .i_clk, .i_rst_n, .i_req,
        .o_task_valid (task_valid), .o_task (task_in), .i_task_ready (!q_full)
    );

    lflb_queue u_queue (
        .i_clk, .i_rst_n,
        .i_push (task_valid), .i_data (task_in), .o_full (q_full),
        .i_pop (q_pop), .o_data (task_out), .o_empty (q_empty)
    );

    lflb_back u_back (
        .i_clk, .i_rst_n, .i_num_workers (r_num_workers),
        .i_task_valid (!q_empty), .i_task (task_out), .o_task_pop (q_pop),
        .o_rsp, .o_busy (busy)
    );

    // result never stalled away
    `AST_NEXT(a_rsp_hold, i_clk, i_rst_n, o_rsp.valid && !o_rsp.ready, o_rsp.valid)
    // chosen worker is within the active set
    `AST_IMPL(a_worker_range, i_clk, i_rst_n, o_rsp.valid,
              WorkerCntW'(o_rsp.payload.assigned_worker) < r_num_workers
              || r_num_workers == '0 || r_num_workers > WorkerCntW'(MaxWorkers))
    // a queued task means the back end reports busy
    `AST_IMPL(a_busy, i_clk, i_rst_n, !q_empty, busy)
endmodule

@@ hw/rtl/lflb_front.sv @@
// collects a batch, insertion sorts an index list, then streams tasks in order
module lflb_front import lflb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    lflb_req_if.sink i_req,
    output logic  o_task_valid,
    output t_task o_task,
    input  logic  i_task_ready
);
    logic [47:0]         r_store [MaxTasks];
    logic [TaskIdxW-1:0] r_order [MaxTasks];
    t_front_state        r_state, n_state;
    logic [TaskCntW-1:0] r_fill, n_fill, r_i, n_i, r_j, n_j;
    logic                r_lost, n_lost;
    logic [47:0]         r_key_e, r_cmp_e;
    logic [47:0]         r_emit_e;
    logic [TaskIdxW-1:0] r_prev;
    logic                st_we, ord_we;
    logic [TaskIdxW-1:0] ord_wa, ord_wd, rd_idx;
    logic                capture_key, capture_cmp, capture_emit;

    assign i_req.ready = (r_state == S_LOAD);
    assign o_task.job_id    = r_emit_e[47:32];
    assign o_task.task_load = r_emit_e[31:0];
    assign o_task.overflow  = r_lost;
    assign o_task.last      = (r_i == r_fill - TaskCntW'(1));

    always_comb begin
        n_state = r_state; n_fill = r_fill; n_i = r_i; n_j = r_j; n_lost = r_lost;
        st_we = 1'b0; ord_we = 1'b0; ord_wa = r_j[TaskIdxW-1:0]; ord_wd = r_prev;
        rd_idx = r_prev; capture_key = 1'b0; capture_cmp = 1'b0; capture_emit = 1'b0;
        o_task_valid = 1'b0;
        case (r_state)
            S_LOAD: begin
                if (i_req.valid) begin
                    if (r_fill < TaskCntW'(MaxTasks)) begin
                        st_we = 1'b1; n_fill = r_fill + 1'b1;
                    end else begin
                        n_lost = 1'b1;
                    end
                    if (i_req.payload.batch_last) begin
                        n_i = '0; n_state = S_SORT_RD;
                    end
                end
            end
            S_SORT_RD: begin
                // fetch key task i, start shifting from slot i
                if (r_i == r_fill) begin
                    n_i = '0; n_state = S_EMIT_RD;
                end else begin
                    capture_key = 1'b1; n_j = r_i; n_state = S_SORT_CMP;
                end
            end
            S_SORT_CMP: begin
                // fetch entry at order[j-1]
                if (r_j == '0) begin
                    ord_wa = '0; ord_wd = r_i[TaskIdxW-1:0]; ord_we = 1'b1;
                    n_i = r_i + 1'b1; n_state = S_SORT_RD;
                end else begin
                    capture_cmp = 1'b1; n_state = S_SORT_WR;
                end
            end
            S_SORT_WR: begin
                ord_we = 1'b1;
                if (r_cmp_e[31:0] < r_key_e[31:0]) begin
                    ord_wd = r_prev; n_j = r_j - 1'b1; n_state = S_SORT_CMP;
                end else begin
                    ord_wd = r_i[TaskIdxW-1:0]; n_i = r_i + 1'b1; n_state = S_SORT_RD;
                end
            end
            S_EMIT_RD: begin
                if (r_i == r_fill) begin
                    n_fill = '0; n_lost = 1'b0; n_state = S_LOAD;
                end else begin
                    capture_emit = 1'b1; n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_task_valid = 1'b1;
                if (i_task_ready) begin
                    n_i = r_i + 1'b1; n_state = S_EMIT_RD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD; r_fill <= '0; r_lost <= 1'b0; r_i <= '0; r_j <= '0;
        end else begin
            r_state <= n_state; r_fill <= n_fill; r_lost <= n_lost; r_i <= n_i; r_j <= n_j;
        end
    end

    // order list read: previous slot for compare, slot i when emitting
    always_ff @(posedge i_clk) begin
        if (ord_we) r_order[ord_wa] <= ord_wd;
        if (n_state == S_EMIT_RD) r_prev <= r_order[n_i[TaskIdxW-1:0]];
        else r_prev <= r_order[n_j[TaskIdxW-1:0] - TaskIdxW'(1)];
    end

    // task store: one write port, registered reads into the key, compare and emit registers
    always_ff @(posedge i_clk) begin
        if (st_we)
            r_store[r_fill[TaskIdxW-1:0]] <= {i_req.payload.job_id, i_req.payload.task_load};
        if (capture_key) r_key_e <= r_store[r_i[TaskIdxW-1:0]];
        if (capture_cmp) r_cmp_e <= r_store[r_prev];
        if (capture_emit) r_emit_e <= r_store[r_prev];
    end
endmodule

@@ hw/rtl/lflb_queue.sv @@
// small fifo between sorter and assigner
module lflb_queue import lflb_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_task i_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_task o_data,
    output logic  o_empty
);
    localparam int PtrW = $clog2(QueueDepth);
    t_task           r_mem [QueueDepth];
    logic [PtrW-1:0] r_wp, r_rp;
    logic [PtrW:0]   r_cnt;

    assign o_full  = (r_cnt == (PtrW+1)'(QueueDepth));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push && !o_full) r_wp <= r_wp + 1'b1;
            if (i_pop && !o_empty) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PtrW+1)'(i_push && !o_full) - (PtrW+1)'(i_pop && !o_empty);
        end
    end
endmodule

@@ hw/rtl/lflb_back.sv @@
// per task: clear worker memory at a batch start, scan it for the least load, add, then send the result
module lflb_back import lflb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic [WorkerCntW-1:0] i_num_workers,
    input  logic  i_task_valid,
    input  t_task i_task,
    output logic  o_task_pop,
    lflb_rsp_if.source o_rsp,
    output logic  o_busy
);
    logic [TotalW-1:0]     r_loads [MaxWorkers];
    t_back_state           r_state, n_state;
    logic [WorkerIdxW:0]   r_w, n_w, r_nw;
    logic [WorkerIdxW-1:0] r_best, n_best;
    logic [TotalW-1:0]     r_best_ld, n_best_ld, r_rd;
    logic                  r_first, n_first;
    t_task                 r_task;
    logic                  r_ovalid;
    t_rsp                  r_rsp;
    logic                  ld_we;
    logic [WorkerIdxW-1:0] ld_wa;
    logic [TotalW-1:0]     ld_wd, sum;
    logic [WorkerIdxW:0]   nw_eff;

    always_comb begin
        nw_eff = i_num_workers;
        if (i_num_workers == '0) nw_eff = (WorkerIdxW+1)'(1);
        else if (i_num_workers > WorkerCntW'(MaxWorkers)) nw_eff = (WorkerIdxW+1)'(MaxWorkers);
    end

    assign sum = r_best_ld + TotalW'(r_task.task_load);
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.payload = r_rsp;
    assign o_busy = (r_state != B_IDLE) || r_ovalid || i_task_valid;

    always_comb begin
        n_state = r_state; n_w = r_w; n_best = r_best; n_best_ld = r_best_ld;
        n_first = r_first; o_task_pop = 1'b0;
        ld_we = 1'b0; ld_wa = r_w[WorkerIdxW-1:0]; ld_wd = '0;
        case (r_state)
            B_IDLE: begin
                if (i_task_valid) begin
                    o_task_pop = 1'b1;
                    n_w = '0;
                    n_state = r_first ? B_CLEAR : B_SCAN;
                end
            end
            B_CLEAR: begin
                // clear every worker row once per batch
                ld_we = 1'b1;
                n_w = r_w + 1'b1;
                if (r_w == (WorkerIdxW+1)'(MaxWorkers - 1)) begin
                    n_w = '0; n_first = 1'b0; n_state = B_SCAN;
                end
            end
            B_SCAN: begin
                n_state = B_SCAN_WAIT;
            end
            B_SCAN_WAIT: begin
                // r_rd holds load of worker r_w
                if (r_w == '0 || r_rd < r_best_ld) begin
                    n_best = r_w[WorkerIdxW-1:0]; n_best_ld = r_rd;
                end
                n_w = r_w + 1'b1;
                n_state = (r_w + 1'b1 == r_nw) ? B_UPDATE : B_SCAN;
            end
            B_UPDATE: begin
                ld_we = 1'b1; ld_wa = r_best; ld_wd = sum;
                n_best_ld = sum;
                n_state = B_OUT;
            end
            B_OUT: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_state = B_IDLE;
                    if (r_task.last) n_first = 1'b1;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ld_we) r_loads[ld_wa] <= ld_wd;
        r_rd <= r_loads[r_w[WorkerIdxW-1:0]];
        if (r_state == B_IDLE && i_task_valid) begin
            r_task <= i_task; r_nw <= nw_eff;
        end
        r_best <= n_best; r_best_ld <= n_best_ld;
        if (r_state == B_OUT && (!r_ovalid || o_rsp.ready)) begin
            r_rsp.assigned_job    <= r_task.job_id;
            r_rsp.assigned_worker <= r_best;
            r_rsp.worker_total    <= r_best_ld;
            r_rsp.overflow        <= r_task.overflow;
            r_rsp.result_last     <= r_task.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE; r_w <= '0; r_first <= 1'b1; r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state; r_w <= n_w; r_first <= n_first;
            if (r_state == B_OUT && (!r_ovalid || o_rsp.ready)) r_ovalid <= 1'b1;
            else if (o_rsp.ready) r_ovalid <= 1'b0;
        end
    end
endmodule

@@ tb/largest_first_load_balancer_test.sv @@
`timescale 1ns / 100ps
module largest_first_load_balancer_test;
    import lflb_pkg::*;

    localparam int ClkPeriod = 12;
    localparam int IdleLimit = 200000;

    logic i_clk;
    logic i_rst_n;
    logic [WorkerCntW-1:0] num_workers_wr;
    logic num_workers_we;

    lflb_req_if req_bus ();
    lflb_rsp_if rsp_bus ();

    largest_first_load_balancer dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_num_workers    (num_workers_wr),
        .i_num_workers_we (num_workers_we),
        .i_req            (req_bus.sink),
        .o_rsp            (rsp_bus.source)
    );

    // model of the balancer: current batch and the register
    logic [15:0] batch_jobs [$];
    logic [31:0] batch_loads [$];
    logic        batch_lost;
    logic [7:0]  workers_reg;
    t_rsp        assignments_due [$];

    int  error_count;
    int  idle_cycles;
    bit  send_gaps;     // random gaps on the request side
    bit  recv_stalls;   // random stalls on the result side
    int  hold_off;      // long result stall, counted down by the receiver

    initial begin
        i_clk = 1'b0;
        forever #(ClkPeriod / 2) i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        error_count++;
    endtask

    // stable descending sort, then least-loaded worker with lowest index
    task automatic balance_batch();
        int order [$];
        logic [37:0] totals [128];
        int n, pos, active, best;
        t_rsp r;
        n = batch_jobs.size();
        for (int i = 0; i < n; i++) begin
            pos = order.size();
            // insert after every entry whose load is not smaller
            while (pos > 0 && batch_loads[order[pos - 1]] < batch_loads[i]) pos--;
            order.insert(pos, i);
        end
        active = (workers_reg == 0) ? 1 : ((workers_reg > MaxWorkers) ? MaxWorkers
                                                                       : workers_reg);
        foreach (totals[w]) totals[w] = '0;
        for (int i = 0; i < n; i++) begin
            best = 0;
            for (int w = 1; w < active; w++)
                if (totals[w] < totals[best]) best = w;
            totals[best] += batch_loads[order[i]];
            r.assigned_job    = batch_jobs[order[i]];
            r.assigned_worker = best[6:0];
            r.worker_total    = totals[best];
            r.overflow        = batch_lost;
            r.result_last     = (i == n - 1);
            assignments_due = {assignments_due, r};
        end
        batch_jobs.delete();
        batch_loads.delete();
        batch_lost = 1'b0;
    endtask

    // drives one request at the falling edge, holds it until accepted
    task automatic send_request(input logic [15:0] job, input logic [31:0] load,
                                input logic last);
        int gap;
        @(negedge i_clk);
        if (send_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_bus.valid   <= 1'b1;
        req_bus.payload <= '{job_id: job, task_load: load, batch_last: last};
        do @(posedge i_clk); while (!req_bus.ready);
        if (batch_jobs.size() < MaxTasks) begin
            batch_jobs = {batch_jobs, job};
            batch_loads = {batch_loads, load};
        end else begin
            batch_lost = 1'b1;
        end
        if (last) begin
            balance_batch();
            @(negedge i_clk);
            req_bus.valid <= 1'b0;
        end
    endtask

    task automatic send_batch(input int n, input int load_max);
        logic [31:0] load;
        for (int i = 0; i < n; i++) begin
            load = (load_max < 0) ? $urandom() : $urandom_range(0, load_max);
            send_request(16'($urandom_range(0, 16'hffff)), load, i == n - 1);
        end
    endtask

    // register writes only once the block has drained
    task automatic write_num_workers(input logic [7:0] value);
        wait (assignments_due.size() == 0);
        repeat (600) @(negedge i_clk);
        num_workers_wr <= value;
        num_workers_we <= 1'b1;
        @(negedge i_clk);
        num_workers_we <= 1'b0;
        workers_reg = value;
    endtask

    // result receiver: random stalls or a long hold-off, checks each result
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_bus.ready <= 1'b0;
        end else if (recv_stalls && $urandom_range(0, 5) == 0) begin
            hold_off <= $urandom_range(0, 12);
            rsp_bus.ready <= 1'b0;
        end else begin
            rsp_bus.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_rsp want;
        t_rsp got;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            got = rsp_bus.payload;
            if (assignments_due.size() == 0) begin
                report_mismatch("unexpected result", got.assigned_job, 0);
            end else begin
                want = assignments_due.pop_front();
                if (got.assigned_job !== want.assigned_job)
                    report_mismatch("job", got.assigned_job, want.assigned_job);
                if (got.assigned_worker !== want.assigned_worker)
                    report_mismatch("worker", got.assigned_worker, want.assigned_worker);
                if (got.worker_total !== want.worker_total)
                    report_mismatch("total", got.worker_total, want.worker_total);
                if (got.overflow !== want.overflow)
                    report_mismatch("overflow", got.overflow, want.overflow);
                if (got.result_last !== want.result_last)
                    report_mismatch("last", got.result_last, want.result_last);
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // extremes of the fields, single-task batch, equal loads keep arrival order
    task automatic test_directed();
        write_num_workers(8'd3);
        send_request(16'h0000, 32'h0000_0000, 1'b1);
        send_request(16'hffff, 32'hffff_ffff, 1'b0);
        send_request(16'h5555, 32'h0000_0007, 1'b0);
        send_request(16'haaaa, 32'h0000_0007, 1'b0);
        send_request(16'h1234, 32'h0000_0007, 1'b0);
        send_request(16'h8001, 32'h8000_0000, 1'b1);
        send_batch(6, 3);
        // zero workers acts as one
        write_num_workers(8'd0);
        send_batch(5, -1);
    endtask

    // saturation above the worker capacity and the full-range register
    task automatic test_num_workers_extremes();
        write_num_workers(8'd255);
        send_batch(20, 1000);
        write_num_workers(8'd128);
        send_batch(8, -1);
        write_num_workers(8'd129);
        send_batch(4, 10);
    endtask

    // at capacity, then more than capacity: dropped items set overflow, closing one dropped too
    task automatic test_overflow();
        write_num_workers(8'd5);
        send_batch(64, -1);
        send_batch(67, 100);
    endtask

    // receiver stalls long while requests keep coming, block backs up
    task automatic test_backpressure();
        write_num_workers(8'd2);
        @(posedge i_clk);
        hold_off = 400;
        send_batch(10, 50);
        send_batch(10, 50);
    endtask

    task automatic test_random();
        bit [7:0] settings [5] = '{8'd1, 8'd4, 8'd7, 8'd16, 8'd64};
        for (int b = 0; b < 10; b++) begin
            // worker count may change before every other batch
            if (b % 2 == 0) write_num_workers(settings[$urandom_range(0, 4)]);
            send_batch($urandom_range(1, 16), ($urandom_range(0, 1) != 0) ? -1 : 20);
        end
        // final stretch with no idling
        send_gaps = 1'b0;
        recv_stalls = 1'b0;
        for (int b = 0; b < 6; b++) send_batch($urandom_range(1, 10), -1);
    endtask

    initial begin
        error_count = 0;
        idle_cycles = 0;
        hold_off = 0;
        batch_lost = 1'b0;
        workers_reg = 8'd1;
        send_gaps = 1'b1;
        recv_stalls = 1'b1;
        i_rst_n = 1'b0;
        num_workers_wr = 8'd1;
        num_workers_we = 1'b0;
        req_bus.valid = 1'b0;
        req_bus.payload = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_num_workers_extremes();
        test_overflow();
        test_backpressure();
        test_random();

        wait (assignments_due.size() == 0);
        repeat (600) @(negedge i_clk);
        if (error_count == 0 && assignments_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/lflb_pkg.sv
hw/rtl/lflb_if.sv
hw/rtl/lflb_front.sv
hw/rtl/lflb_queue.sv
hw/rtl/lflb_back.sv
hw/rtl/largest_first_load_balancer.sv
tb/largest_first_load_balancer_test.sv
